/* rtl/yuvcrm_pkg.sv */
package yuvcrm_pkg;

  // Widths of the stream fields and of the size registers.
  localparam int DIM_W    = 13;
  localparam int POS_W    = 12;
  localparam int SAMPLE_W = 8;
  localparam int ADDR_W   = 24;
  localparam int PLANE_W  = 2;
  localparam int PROD_W   = POS_W + DIM_W;

  // APB register file.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Largest frame dimension that still produces results.
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

  localparam logic [DIM_W-1:0] RST_INPUT_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_INPUT_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] RST_CROP_WIDTH   = DIM_W'(480);
  localparam logic [DIM_W-1:0] RST_CROP_HEIGHT  = DIM_W'(480);

  typedef enum logic [1:0] {
    MODE_CROP    = 2'd0,
    MODE_ROT90   = 2'd1,
    MODE_ROT270M = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Input plane codes; the output swaps the two chroma planes.
  localparam logic [PLANE_W-1:0] PLANE_Y       = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_C1      = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_C2      = 2'd2;
  localparam logic [PLANE_W-1:0] PLANE_INVALID = 2'd3;
  localparam logic [PLANE_W-1:0] OPLANE_Y      = 2'd0;
  localparam logic [PLANE_W-1:0] OPLANE_U      = 2'd1;
  localparam logic [PLANE_W-1:0] OPLANE_V      = 2'd2;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_INPUT_WIDTH  = 3'd1,
    REG_INPUT_HEIGHT = 3'd2,
    REG_CROP_WIDTH   = 3'd3,
    REG_CROP_HEIGHT  = 3'd4
  } reg_idx_t;

endpackage

/* rtl/yuv420_crop_rotate_mirror_address.sv */
// Throughput: one request per cycle unless the output stalls; four register stages
// (offsets, crop test and operand select, multiplier, final add) advance together
// whenever the output is free. Requests outside the crop are dropped at the second
// stage and leave a bubble. Reset (rst_n low, synchronous) empties the pipeline and
// restores the registers to mode crop, input 640x480, crop 480x480.
module yuv420_crop_rotate_mirror_address (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // APB configuration port.
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [yuvcrm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [yuvcrm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [yuvcrm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready,
  // Input stream.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [31:0]                          in_tdata,  // row[11:0], col[23:12], sample[31:24]
  input  logic [yuvcrm_pkg::PLANE_W-1:0]       in_tuser,  // plane[1:0]
  // Output stream.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata, // address[23:0], sample[31:24]
  output logic [yuvcrm_pkg::PLANE_W-1:0]       out_tuser  // plane[1:0]
);

  localparam int DIM_W    = yuvcrm_pkg::DIM_W;
  localparam int POS_W    = yuvcrm_pkg::POS_W;
  localparam int SAMPLE_W = yuvcrm_pkg::SAMPLE_W;
  localparam int ADDR_W   = yuvcrm_pkg::ADDR_W;
  localparam int PLANE_W  = yuvcrm_pkg::PLANE_W;
  localparam int PROD_W   = yuvcrm_pkg::PROD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  yuvcrm_pkg::mode_t   mode_r;
  logic [DIM_W-1:0]    in_w_r, in_h_r, crop_w_r, crop_h_r;
  yuvcrm_pkg::reg_idx_t reg_idx;
  logic                cfg_wr;

  assign reg_idx    = yuvcrm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= yuvcrm_pkg::MODE_CROP;
      in_w_r   <= yuvcrm_pkg::RST_INPUT_WIDTH;
      in_h_r   <= yuvcrm_pkg::RST_INPUT_HEIGHT;
      crop_w_r <= yuvcrm_pkg::RST_CROP_WIDTH;
      crop_h_r <= yuvcrm_pkg::RST_CROP_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        yuvcrm_pkg::REG_MODE:         mode_r   <= yuvcrm_pkg::mode_t'(cfg_pwdata[1:0]);
        yuvcrm_pkg::REG_INPUT_WIDTH:  in_w_r   <= cfg_pwdata[DIM_W-1:0];
        yuvcrm_pkg::REG_INPUT_HEIGHT: in_h_r   <= cfg_pwdata[DIM_W-1:0];
        yuvcrm_pkg::REG_CROP_WIDTH:   crop_w_r <= cfg_pwdata[DIM_W-1:0];
        yuvcrm_pkg::REG_CROP_HEIGHT:  crop_h_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      yuvcrm_pkg::REG_MODE:         cfg_prdata = 32'(mode_r);
      yuvcrm_pkg::REG_INPUT_WIDTH:  cfg_prdata = 32'(in_w_r);
      yuvcrm_pkg::REG_INPUT_HEIGHT: cfg_prdata = 32'(in_h_r);
      yuvcrm_pkg::REG_CROP_WIDTH:   cfg_prdata = 32'(crop_w_r);
      yuvcrm_pkg::REG_CROP_HEIGHT:  cfg_prdata = 32'(crop_h_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when it is empty or its successor moves.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic go1, go2, go3, go4;

  assign go4       = !s4_v_r || out_tready;
  assign go3       = !s3_v_r || go4;
  assign go2       = !s2_v_r || go3;
  assign go1       = !s1_v_r || go2;
  assign in_tready = go1;

  // ---------------------------------------------------------------------------
  // Stage 1: frame checks and offsets from the crop start.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]    in_row, in_col;
  logic [SAMPLE_W-1:0] in_sample;
  logic                s0_chroma, s0_cfg_ok;
  logic [DIM_W-1:0]    h_diff, w_diff, start_row, start_col;
  logic [DIM_W:0]      s0_drow, s0_dcol;
  logic [PLANE_W-1:0]  s0_oplane;

  assign in_row    = in_tdata[11:0];
  assign in_col    = in_tdata[23:12];
  assign in_sample = in_tdata[31:24];

  always_comb begin
    s0_chroma = (in_tuser != yuvcrm_pkg::PLANE_Y);
    s0_oplane = (in_tuser == yuvcrm_pkg::PLANE_C1) ? yuvcrm_pkg::OPLANE_V :
                (in_tuser == yuvcrm_pkg::PLANE_C2) ? yuvcrm_pkg::OPLANE_U :
                                                     yuvcrm_pkg::OPLANE_Y;
    s0_cfg_ok = (mode_r != yuvcrm_pkg::MODE_NONE) &&
                (in_tuser != yuvcrm_pkg::PLANE_INVALID) &&
                (in_w_r <= yuvcrm_pkg::MAX_DIM) && (in_h_r <= yuvcrm_pkg::MAX_DIM) &&
                (crop_w_r <= yuvcrm_pkg::MAX_DIM) && (crop_h_r <= yuvcrm_pkg::MAX_DIM) &&
                (crop_w_r <= in_w_r) && (crop_h_r <= in_h_r);
    h_diff    = in_h_r - crop_h_r;
    w_diff    = in_w_r - crop_w_r;
    // Crop keeps the bottom rows in modes crop and rotate 90, the right columns in
    // the mirrored mode; the chroma start is half the luma margin, rounded down.
    start_row = s0_chroma ? (h_diff >> 1) : h_diff;
    start_col = s0_chroma ? (w_diff >> 1) : w_diff;
    s0_drow   = {2'b00, in_row} - {1'b0, start_row};
    s0_dcol   = {2'b00, in_col} - {1'b0, start_col};
  end

  logic                s1_chroma_r;
  logic [PLANE_W-1:0]  s1_oplane_r;
  logic [POS_W-1:0]    s1_row_r, s1_col_r;
  logic [DIM_W:0]      s1_drow_r, s1_dcol_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (go1) begin
      s1_v_r <= in_tvalid && s0_cfg_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_chroma_r <= s0_chroma;
      s1_oplane_r <= s0_oplane;
      s1_row_r    <= in_row;
      s1_col_r    <= in_col;
      s1_drow_r   <= s0_drow;
      s1_dcol_r   <= s0_dcol;
      s1_sample_r <= in_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: crop test and multiplier operand selection.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] hp, wp, chp, cwp;
  logic [DIM_W-1:0] row_x, col_x, rel_row, rel_col, mirror_col, rot_rest, mir_rest;
  logic             in_frame, s1_keep;
  logic [POS_W-1:0] s1_mul_a, s1_addend;
  logic [DIM_W-1:0] s1_mul_b;

  always_comb begin
    hp         = s1_chroma_r ? (in_h_r >> 1)   : in_h_r;
    wp         = s1_chroma_r ? (in_w_r >> 1)   : in_w_r;
    chp        = s1_chroma_r ? (crop_h_r >> 1) : crop_h_r;
    cwp        = s1_chroma_r ? (crop_w_r >> 1) : crop_w_r;
    row_x      = {1'b0, s1_row_r};
    col_x      = {1'b0, s1_col_r};
    rel_row    = s1_drow_r[DIM_W-1:0];
    rel_col    = s1_dcol_r[DIM_W-1:0];
    mirror_col = cwp - DIM_W'(1) - rel_col;
    rot_rest   = chp - DIM_W'(1) - rel_row;
    mir_rest   = chp - DIM_W'(1) - row_x;
    in_frame   = (row_x < hp) && (col_x < wp);
    unique case (mode_r)
      yuvcrm_pkg::MODE_CROP: begin
        s1_keep   = in_frame && !s1_drow_r[DIM_W] && (rel_row < chp) && (col_x < cwp);
        s1_mul_a  = rel_row[POS_W-1:0];
        s1_mul_b  = crop_w_r;
        s1_addend = s1_col_r;
      end
      yuvcrm_pkg::MODE_ROT90: begin
        s1_keep   = in_frame && !s1_drow_r[DIM_W] && (rel_row < chp) && (col_x < cwp);
        s1_mul_a  = s1_col_r;
        s1_mul_b  = crop_h_r;
        s1_addend = rot_rest[POS_W-1:0];
      end
      yuvcrm_pkg::MODE_ROT270M: begin
        s1_keep   = in_frame && (row_x < chp) && !s1_dcol_r[DIM_W] && (rel_col < cwp);
        s1_mul_a  = mirror_col[POS_W-1:0];
        s1_mul_b  = crop_h_r;
        s1_addend = mir_rest[POS_W-1:0];
      end
      default: begin
        s1_keep   = 1'b0;
        s1_mul_a  = '0;
        s1_mul_b  = '0;
        s1_addend = '0;
      end
    endcase
  end

  logic                s2_chroma_r;
  logic [PLANE_W-1:0]  s2_oplane_r;
  logic [SAMPLE_W-1:0] s2_sample_r;
  logic [POS_W-1:0]    s2_mul_a_r, s2_addend_r;
  logic [DIM_W-1:0]    s2_mul_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (go2) begin
      s2_v_r <= s1_v_r && s1_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      s2_chroma_r <= s1_chroma_r;
      s2_oplane_r <= s1_oplane_r;
      s2_sample_r <= s1_sample_r;
      s2_mul_a_r  <= s1_mul_a;
      s2_mul_b_r  <= s1_mul_b;
      s2_addend_r <= s1_addend;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: the multiply.
  // ---------------------------------------------------------------------------
  logic                s3_chroma_r;
  logic [PLANE_W-1:0]  s3_oplane_r;
  logic [SAMPLE_W-1:0] s3_sample_r;
  logic [POS_W-1:0]    s3_addend_r;
  logic [PROD_W-1:0]   s3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (go3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      s3_chroma_r <= s2_chroma_r;
      s3_oplane_r <= s2_oplane_r;
      s3_sample_r <= s2_sample_r;
      s3_addend_r <= s2_addend_r;
      s3_prod_r   <= PROD_W'(s2_mul_a_r) * PROD_W'(s2_mul_b_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: halve the product for chroma, add the offset, wrap to 24 bits.
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]   scaled;
  logic [ADDR_W-1:0]   addr_nxt;
  logic [PLANE_W-1:0]  s4_oplane_r;
  logic [SAMPLE_W-1:0] s4_sample_r;
  logic [ADDR_W-1:0]   s4_addr_r;

  assign scaled   = s3_chroma_r ? (s3_prod_r >> 1) : s3_prod_r;
  assign addr_nxt = scaled[ADDR_W-1:0] + ADDR_W'(s3_addend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (go4) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go4) begin
      s4_oplane_r <= s3_oplane_r;
      s4_sample_r <= s3_sample_r;
      s4_addr_r   <= addr_nxt;
    end
  end

  assign out_tvalid = s4_v_r;
  assign out_tdata  = {s4_sample_r, s4_addr_r};
  assign out_tuser  = s4_oplane_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A stalled request in the first stage keeps its position data.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !go2 |=> s1_v_r && $stable(s1_row_r) && $stable(s1_col_r))
    else $error("stage 1 lost or changed a stalled request");

  // Only luma maps to the luma output plane; chroma is swapped onto U or V.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> ((s2_oplane_r == yuvcrm_pkg::OPLANE_Y) == !s2_chroma_r))
    else $error("output plane does not match the input plane kind");

  // An empty first stage always takes a new request.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_tready)
    else $error("input stalled with an empty first stage");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int HALF_PERIOD = 6;
  localparam int IDLE_LIMIT  = 5000;
  localparam int PIPE_DRAIN  = 8;

  localparam int DIM_W      = yuvcrm_pkg::DIM_W;
  localparam int POS_W      = yuvcrm_pkg::POS_W;
  localparam int SAMPLE_W   = yuvcrm_pkg::SAMPLE_W;
  localparam int ADDR_W     = yuvcrm_pkg::ADDR_W;
  localparam int PLANE_W    = yuvcrm_pkg::PLANE_W;
  localparam int CFG_DATA_W = yuvcrm_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W = yuvcrm_pkg::CFG_ADDR_W;

  typedef struct packed {
    logic [PLANE_W-1:0]  plane;
    logic [ADDR_W-1:0]   address;
    logic [SAMPLE_W-1:0] sample;
  } placed_t;

  typedef struct {
    yuvcrm_pkg::mode_t mode;
    logic [DIM_W-1:0]  iw;
    logic [DIM_W-1:0]  ih;
    logic [DIM_W-1:0]  cw;
    logic [DIM_W-1:0]  ch;
  } frame_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;   // row[11:0], col[23:12], sample[31:24]
  logic [PLANE_W-1:0]    in_tuser;   // plane[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;  // address[23:0], sample[31:24]
  logic [PLANE_W-1:0]    out_tuser;  // plane[1:0]

  placed_t        pending_placements[$];
  frame_setting_t setting;
  int             failures = 0;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             idle_cycles;

  yuv420_crop_rotate_mirror_address u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // Where a sample lands in the output frame, if it survives the crop.
  function automatic bit place_sample(input frame_setting_t f,
                                      input logic [PLANE_W-1:0] plane,
                                      input logic [POS_W-1:0] row,
                                      input logic [POS_W-1:0] col,
                                      input logic [SAMPLE_W-1:0] smp, output placed_t pl);
    longint w, h, cw, ch, wp, hp, cwp, chp, rr, cc, start, addr;
    bit chroma;
    pl = '0;
    if (f.mode == yuvcrm_pkg::MODE_NONE || plane == yuvcrm_pkg::PLANE_INVALID) return 1'b0;
    w = f.iw;
    h = f.ih;
    cw = f.cw;
    ch = f.ch;
    if (w > yuvcrm_pkg::MAX_DIM || h > yuvcrm_pkg::MAX_DIM ||
        cw > yuvcrm_pkg::MAX_DIM || ch > yuvcrm_pkg::MAX_DIM) return 1'b0;
    if (cw > w || ch > h) return 1'b0;
    chroma = (plane != yuvcrm_pkg::PLANE_Y);
    wp = chroma ? w / 2 : w;
    hp = chroma ? h / 2 : h;
    cwp = chroma ? cw / 2 : cw;
    chp = chroma ? ch / 2 : ch;
    rr = row;
    cc = col;
    if (rr >= hp || cc >= wp) return 1'b0;
    if (f.mode == yuvcrm_pkg::MODE_CROP || f.mode == yuvcrm_pkg::MODE_ROT90) begin
      start = chroma ? (h - ch) / 2 : h - ch;
      rr = rr - start;
      if (rr < 0 || rr >= chp || cc >= cwp) return 1'b0;
      if (f.mode == yuvcrm_pkg::MODE_CROP) begin
        addr = chroma ? (rr * cw) / 2 + cc : rr * cw + cc;
      end else begin
        addr = chroma ? (cc * ch) / 2 + (chp - 1 - rr) : cc * ch + (chp - 1 - rr);
      end
    end else begin
      // Mirrored rotation keeps the top rows and the right-hand columns.
      start = chroma ? (w - cw) / 2 : w - cw;
      if (rr >= chp) return 1'b0;
      cc = cc - start;
      if (cc < 0 || cc >= cwp) return 1'b0;
      addr = chroma ? ((cwp - 1 - cc) * ch) / 2 + (chp - 1 - rr)
                    : (cwp - 1 - cc) * ch + (chp - 1 - rr);
    end
    if (addr < 0) return 1'b0;
    pl.plane = chroma ? ((plane == yuvcrm_pkg::PLANE_C1) ? yuvcrm_pkg::OPLANE_V
                                                         : yuvcrm_pkg::OPLANE_U)
                      : yuvcrm_pkg::OPLANE_Y;
    pl.address = addr[ADDR_W-1:0];
    pl.sample = smp;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    placed_t want;
    placed_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.plane = out_tuser;
      got.address = out_tdata[ADDR_W-1:0];
      got.sample = out_tdata[31:24];
      if (pending_placements.size() == 0) begin
        report_failure($sformatf("unexpected result: plane %0d address %0d sample %0d",
                                 got.plane, got.address, got.sample));
      end else begin
        want = pending_placements.pop_front();
        if (got.plane !== want.plane || got.address !== want.address ||
            got.sample !== want.sample) begin
          report_failure($sformatf(
            "expected plane %0d addr %0d sample %0d, got plane %0d addr %0d sample %0d",
            want.plane, want.address, want.sample, got.plane, got.address, got.sample));
        end
      end
    end
  end

  // Register writes leave psel high; the caller closes the transfer once.
  task automatic write_reg(input yuvcrm_pkg::reg_idx_t idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      yuvcrm_pkg::REG_MODE:         setting.mode = yuvcrm_pkg::mode_t'(value[1:0]);
      yuvcrm_pkg::REG_INPUT_WIDTH:  setting.iw = value[DIM_W-1:0];
      yuvcrm_pkg::REG_INPUT_HEIGHT: setting.ih = value[DIM_W-1:0];
      yuvcrm_pkg::REG_CROP_WIDTH:   setting.cw = value[DIM_W-1:0];
      yuvcrm_pkg::REG_CROP_HEIGHT:  setting.ch = value[DIM_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until the pipeline is empty, dropped requests included, then reprograms it.
  task automatic apply_setting(input yuvcrm_pkg::mode_t mode, input int iw, input int ih,
                               input int cw, input int ch);
    recv_stall_pct = 0;
    do @(posedge clk); while (pending_placements.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    write_reg(yuvcrm_pkg::REG_MODE, CFG_DATA_W'(mode));
    write_reg(yuvcrm_pkg::REG_INPUT_WIDTH, CFG_DATA_W'(iw));
    write_reg(yuvcrm_pkg::REG_INPUT_HEIGHT, CFG_DATA_W'(ih));
    write_reg(yuvcrm_pkg::REG_CROP_WIDTH, CFG_DATA_W'(cw));
    write_reg(yuvcrm_pkg::REG_CROP_HEIGHT, CFG_DATA_W'(ch));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Leaves in_tvalid high so that back-to-back requests need no extra assignment.
  task automatic send_item(input logic [PLANE_W-1:0] plane, input int row, input int col,
                           input int smp);
    placed_t pl;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= plane;
    in_tdata <= {smp[7:0], col[11:0], row[11:0]};
    do @(posedge clk); while (!in_tready);
    if (place_sample(setting, plane, row[11:0], col[11:0], smp[7:0], pl))
      pending_placements.push_back(pl);
  endtask

  task automatic run_phase(input yuvcrm_pkg::mode_t mode, input int iw, input int ih,
                           input int cw, input int ch, input int n_items, input int send_pct,
                           input int recv_pct, input bit pause_mid);
    int kind;
    int p;
    longint w, h, cwl, chl, wp, hp, cwp, chp, rlo, rn, clo, cn, r, c;
    bit chroma;
    logic [PLANE_W-1:0] plane;
    apply_setting(mode, iw, ih, cw, ch);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int k = 0; k < n_items; k++) begin
      if (pause_mid && k == n_items / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_placements.size() != 0);
      end
      kind = $urandom_range(99);
      p = $urandom_range(2);
      plane = p[PLANE_W-1:0];
      chroma = (p != 0);
      w = setting.iw;
      h = setting.ih;
      cwl = setting.cw;
      chl = setting.ch;
      wp = chroma ? w / 2 : w;
      hp = chroma ? h / 2 : h;
      cwp = chroma ? cwl / 2 : cwl;
      chp = chroma ? chl / 2 : chl;
      if (setting.mode == yuvcrm_pkg::MODE_ROT270M) begin
        rlo = 0;
        clo = chroma ? (w - cwl) / 2 : w - cwl;
      end else begin
        rlo = chroma ? (h - chl) / 2 : h - chl;
        clo = 0;
      end
      rn = chp;
      cn = cwp;
      // Most requests hit the kept area or its border; others the plane border or anywhere.
      if (kind >= 75 || rlo < 0 || clo < 0 || rn <= 0 || cn <= 0) begin
        rlo = 0;
        clo = 0;
        rn = hp;
        cn = wp;
      end
      if (kind >= 90 || rn <= 0 || cn <= 0) begin
        plane = PLANE_W'($urandom_range(3));
        r = $urandom_range(4095);
        c = $urandom_range(4095);
      end else if (kind < 65) begin
        r = rlo + longint'($urandom_range(int'(rn) - 1));
        c = clo + longint'($urandom_range(int'(cn) - 1));
      end else begin
        r = ($urandom_range(1) ? rlo : rlo + rn) - longint'($urandom_range(1));
        c = ($urandom_range(1) ? clo : clo + cn) - longint'($urandom_range(1));
      end
      if (r < 0 || r > 4095) r = $urandom_range(4095);
      if (c < 0 || c > 4095) c = $urandom_range(4095);
      send_item(plane, int'(r), int'(c), $urandom_range(255));
    end
    in_tvalid <= 1'b0;
    send_idle_pct = 0;
  endtask

  task automatic test_crop_edges();
    apply_setting(yuvcrm_pkg::MODE_CROP, 640, 480, 480, 480);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 0, 0);
    send_item(yuvcrm_pkg::PLANE_Y, 479, 479, 255);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 480, 17);
    send_item(yuvcrm_pkg::PLANE_Y, 480, 0, 18);
    send_item(yuvcrm_pkg::PLANE_Y, 4095, 4095, 255);
    send_item(yuvcrm_pkg::PLANE_C1, 0, 0, 170);
    send_item(yuvcrm_pkg::PLANE_C2, 239, 239, 85);
    send_item(yuvcrm_pkg::PLANE_C1, 0, 240, 19);
    send_item(yuvcrm_pkg::PLANE_INVALID, 0, 0, 20);
    in_tvalid <= 1'b0;
  endtask

  task automatic test_rotate90_edges();
    apply_setting(yuvcrm_pkg::MODE_ROT90, 640, 480, 480, 480);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 0, 1);
    send_item(yuvcrm_pkg::PLANE_Y, 479, 0, 2);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 479, 3);
    send_item(yuvcrm_pkg::PLANE_C2, 100, 37, 4);
    send_item(yuvcrm_pkg::PLANE_C1, 239, 0, 5);
    in_tvalid <= 1'b0;
  endtask

  task automatic test_rotate270_mirror_edges();
    apply_setting(yuvcrm_pkg::MODE_ROT270M, 640, 480, 480, 480);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 160, 6);
    send_item(yuvcrm_pkg::PLANE_Y, 479, 639, 7);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 159, 8);
    send_item(yuvcrm_pkg::PLANE_Y, 480, 200, 9);
    send_item(yuvcrm_pkg::PLANE_C1, 0, 80, 10);
    send_item(yuvcrm_pkg::PLANE_C2, 239, 319, 11);
    in_tvalid <= 1'b0;
  endtask

  task automatic test_mode_none();
    apply_setting(yuvcrm_pkg::MODE_NONE, 640, 480, 480, 480);
    send_item(yuvcrm_pkg::PLANE_Y, 0, 0, 12);
    send_item(yuvcrm_pkg::PLANE_C2, 5, 5, 13);
    in_tvalid <= 1'b0;
  endtask

  // Settings under which nothing, or only part of a frame, comes out.
  task automatic test_special_settings();
    run_phase(yuvcrm_pkg::MODE_CROP, 8191, 480, 480, 480, 10, 0, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT90, 10, 10, 20, 8, 10, 36, 36, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT270M, 20, 20, 8, 0, 10, 84, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_CROP, 0, 0, 0, 0, 5, 0, 84, 1'b0);
    run_phase(yuvcrm_pkg::MODE_NONE, 64, 64, 32, 32, 10, 0, 84, 1'b0);
    run_phase(yuvcrm_pkg::MODE_CROP, 15, 13, 9, 7, 50, 84, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT90, 9, 7, 5, 3, 40, 0, 84, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT270M, 13, 11, 7, 5, 40, 36, 36, 1'b0);
  endtask

  task automatic test_random_sweep();
    int iw;
    int ih;
    run_phase(yuvcrm_pkg::MODE_CROP, 640, 480, 480, 480, 40, 0, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT90, 16, 12, 10, 8, 60, 84, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT270M, 4096, 4096, 4096, 4096, 60, 0, 84, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT270M, 22, 18, 6, 14, 60, 36, 36, 1'b0);
    run_phase(yuvcrm_pkg::MODE_ROT90, 4096, 2, 2, 2, 40, 0, 0, 1'b0);
    run_phase(yuvcrm_pkg::MODE_CROP, 4096, 4096, 4096, 4096, 50, 36, 36, 1'b1);
    run_phase(yuvcrm_pkg::MODE_ROT90, 4096, 4096, 2, 4096, 30, 0, 0, 1'b0);
    for (int k = 0; k < 2; k++) begin
      iw = 2 * $urandom_range(1, 32);
      ih = 2 * $urandom_range(1, 32);
      run_phase(yuvcrm_pkg::mode_t'($urandom_range(2)), iw, ih,
                2 * $urandom_range(1, iw / 2), 2 * $urandom_range(1, ih / 2), 20,
                84 * k, 84 * (1 - k), 1'b0);
    end
  endtask

  // Ends the run when no request moves on either channel for too long.
  initial begin
    idle_cycles = 0;
    do begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end while (idle_cycles < IDLE_LIMIT);
    $display("[yuv420_crop_rotate_mirror_address] ERROR");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setting.mode = yuvcrm_pkg::MODE_CROP;
    setting.iw = yuvcrm_pkg::RST_INPUT_WIDTH;
    setting.ih = yuvcrm_pkg::RST_INPUT_HEIGHT;
    setting.cw = yuvcrm_pkg::RST_CROP_WIDTH;
    setting.ch = yuvcrm_pkg::RST_CROP_HEIGHT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_crop_edges();
    test_rotate90_edges();
    test_rotate270_mirror_edges();
    test_mode_none();
    test_special_settings();
    test_random_sweep();

    recv_stall_pct = 0;
    do @(posedge clk); while (pending_placements.size() != 0);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (failures == 0) begin
      $display("[yuv420_crop_rotate_mirror_address] OK");
    end else begin
      $display("[yuv420_crop_rotate_mirror_address] ERROR");
    end
    $finish;
  end

endmodule
